// ===== rtl/periodic_step_waveform_lookup_core_assert.svh =====
// assertion macros shared by the rtl
`ifndef PERIODIC_STEP_WAVEFORM_LOOKUP_CORE_ASSERT_SVH
`define PERIODIC_STEP_WAVEFORM_LOOKUP_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, off during reset
`define PSW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, off during reset
`define PSW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PSW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/psw_pkg.sv =====
package psw_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TIME_W      = 32;
  localparam int LEVEL_W     = 16;
  localparam int OUT_W       = LEVEL_W + 1;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SC_W        = 5;
  localparam int CNT_DIV_W   = $clog2(TIME_W);
  localparam int CFG_IDX_W   = 3;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREAPPLY_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREAPPLY_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_SHIFT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT     = 3'd4;

  typedef enum logic [1:0] {
    K_WRITE,
    K_ZERO,
    K_PRE,
    K_EVAL
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_WALK,
    B_LAST
  } back_state_t;

  typedef struct packed {
    logic [TIME_W-1:0]         period;
    logic [TIME_W-1:0]         preapply_time;
    logic signed [LEVEL_W-1:0] preapply_level;
    logic signed [LEVEL_W-1:0] amp_shift;
    logic [SC_W-1:0]           step_count;
  } cfg_t;

  // one classified beat in the queue
  typedef struct packed {
    kind_t                     kind;
    logic [IDX_W-1:0]          idx;
    logic [TIME_W-1:0]         tval;
    logic signed [LEVEL_W-1:0] lvl;
  } item_t;

endpackage

// ===== rtl/psw_front.sv =====
module psw_front (
  input  logic                           start,
  input  logic                           full,
  input  logic                           opcode,
  input  logic [3:0]                     entry_index,
  input  logic [psw_pkg::TIME_W-1:0]     entry_time,
  input  logic signed [psw_pkg::LEVEL_W-1:0] entry_level,
  input  logic [psw_pkg::TIME_W-1:0]     sample_time,
  input  psw_pkg::cfg_t                  cfg,
  output logic                           push,
  output psw_pkg::item_t                 item
);
  import psw_pkg::*;

  assign push = start && !full;

  always_comb begin
    item.idx  = entry_index[IDX_W-1:0];
    item.tval = entry_time;
    item.lvl  = entry_level;
    if (opcode == OP_WRITE) begin
      item.kind = K_WRITE;
    end else if (cfg.period == '0) begin
      item.kind = K_ZERO;
    end else if (sample_time < cfg.preapply_time) begin
      item.kind = K_PRE;
      item.lvl  = cfg.preapply_level;
    end else begin
      // offset into the periodic part, reduced later by the back end
      item.kind = K_EVAL;
      item.tval = sample_time - cfg.preapply_time;
    end
  end

endmodule

// ===== rtl/psw_fifo.sv =====
module psw_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  psw_pkg::item_t push_item,
  input  logic           pop,
  output psw_pkg::item_t pop_item,
  output logic           full,
  output logic           empty
);
  import psw_pkg::*;
  `include "periodic_step_waveform_lookup_core_assert.svh"

  item_t                 slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full     = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  `PSW_ASSERT_IMPL(a_no_push_full, clk, rst, full, !push, "beat pushed into full queue")
  `PSW_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, !empty, "beat popped from empty queue")

endmodule

// ===== rtl/psw_back.sv =====
module psw_back (
  input  logic                              clk,
  input  logic                              rst,
  input  psw_pkg::cfg_t                     cfg,
  input  logic                              empty,
  input  psw_pkg::item_t                    item,
  output logic                              pop,
  output logic signed [psw_pkg::OUT_W-1:0]  level_out,
  output logic                              done
);
  import psw_pkg::*;
  `include "periodic_step_waveform_lookup_core_assert.svh"

  logic [TIME_W-1:0]         times  [TABLE_DEPTH];
  logic signed [LEVEL_W-1:0] levels [TABLE_DEPTH];

  back_state_t               state;
  back_state_t               state_next;
  logic [TIME_W-1:0]         dvd;
  logic [TIME_W-1:0]         rem;
  logic [CNT_DIV_W-1:0]      cnt;
  logic [IDX_W-1:0]          widx;
  logic [IDX_W-1:0]          last_idx;
  logic [TIME_W-1:0]         rd_time;
  logic signed [LEVEL_W-1:0] rd_level;
  logic                      rd_ok;
  logic                      rd_first;
  logic signed [LEVEL_W-1:0] sel_level;
  logic                      hit;
  logic signed [LEVEL_W-1:0] pick;
  logic [TIME_W:0]           rem_sh;
  logic [TIME_W:0]           rem_diff;
  logic [TIME_W-1:0]         rem_next;
  logic                      mem_we;
  logic                      div_load;

  // entries in use, clamped to the table
  always_comb begin
    if (cfg.step_count == '0) begin
      last_idx = '0;
    end else if (cfg.step_count > SC_W'(TABLE_DEPTH)) begin
      last_idx = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(cfg.step_count - 1'b1);
    end
  end

  // one restoring divide step
  always_comb begin
    rem_sh   = {rem, dvd[TIME_W-1]};
    rem_diff = rem_sh - {1'b0, cfg.period};
    rem_next = (rem_sh >= {1'b0, cfg.period}) ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
  end

  // last entry at or below the reduced time wins, entry 0 as fallback
  assign hit  = rd_ok && (rd_first || (rd_time <= rem));
  assign pick = hit ? rd_level : sel_level;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty && item.kind == K_EVAL) begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (cnt == CNT_DIV_W'(TIME_W - 1)) begin
          state_next = B_WALK;
        end
      end
      B_WALK: begin
        if (widx == last_idx) begin
          state_next = B_LAST;
        end
      end
      B_LAST:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    div_load = 1'b0;
    case (state)
      B_IDLE: begin
        pop      = !empty;
        mem_we   = !empty && item.kind == K_WRITE;
        div_load = !empty && item.kind == K_EVAL;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      times[item.idx]  <= item.tval;
      levels[item.idx] <= item.lvl;
    end
    rd_time  <= times[widx];
    rd_level <= levels[widx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
      rd_ok <= 1'b0;
      widx  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      rd_ok <= (state == B_WALK);
      if (state == B_WALK) begin
        widx <= widx + 1'b1;
      end else begin
        widx <= '0;
      end
      if (div_load) begin
        cnt <= '0;
      end else if (state == B_DIV) begin
        cnt <= cnt + 1'b1;
      end
      if (pop && item.kind == K_ZERO) begin
        done <= 1'b1;
      end
      if (pop && item.kind == K_PRE) begin
        done <= 1'b1;
      end
      if (state == B_LAST) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= (widx == '0);
    if (div_load) begin
      dvd <= item.tval;
      rem <= '0;
    end else if (state == B_DIV) begin
      dvd <= {dvd[TIME_W-2:0], 1'b0};
      rem <= rem_next;
    end
    if (state == B_WALK && hit) begin
      sel_level <= rd_level;
    end
    if (pop && item.kind == K_ZERO) begin
      level_out <= '0;
    end else if (pop && item.kind == K_PRE) begin
      level_out <= OUT_W'(item.lvl);
    end else if (state == B_LAST) begin
      level_out <= OUT_W'(pick) + OUT_W'(cfg.amp_shift);
    end
  end

  `PSW_ASSERT_IMPL(a_rem_below_period, clk, rst, state == B_DIV, rem < cfg.period,
    "remainder not reduced below period")
  `PSW_ASSERT_IMPL(a_walk_in_range, clk, rst, state == B_WALK, widx <= last_idx,
    "table walk past last entry in use")
  `PSW_ASSERT_NEXT(a_last_gives_beat, clk, rst, state == B_LAST, done,
    "evaluation finished without a result beat")

endmodule

// ===== rtl/periodic_step_waveform_lookup_core.sv =====
// a table write goes through the queue into the table memory; a zero-period or pre-apply
//   level through it to level_out; an evaluate through 32 divide steps and a table walk
// throughput: other beats one per cycle while the back end is idle; it takes no new beat
//   in an evaluate; a two-entry queue lets the front take beats while the back end works
// reset (synchronous, active high): config to defaults, queue empty, no result pending,
//   table undefined until written; done is a one-cycle strobe, the receiver cannot stall it
module periodic_step_waveform_lookup_core (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode,
  input  logic [3:0]                          entry_index,
  input  logic [psw_pkg::TIME_W-1:0]          entry_time,
  input  logic signed [psw_pkg::LEVEL_W-1:0]  entry_level,
  input  logic [psw_pkg::TIME_W-1:0]          sample_time,
  // result channel
  output logic signed [psw_pkg::OUT_W-1:0]    level_out,
  output logic                                done,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [psw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psw_pkg::TIME_W-1:0]          cfg_data
);
  import psw_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  pop;
  item_t pop_item;
  logic  full;
  logic  empty;

  // config register file, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period         <= '0;
      cfg.preapply_time  <= '0;
      cfg.preapply_level <= '0;
      cfg.amp_shift      <= '0;
      cfg.step_count     <= SC_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD:         cfg.period         <= cfg_data;
        REG_PREAPPLY_TIME:  cfg.preapply_time  <= cfg_data;
        REG_PREAPPLY_LEVEL: cfg.preapply_level <= cfg_data[LEVEL_W-1:0];
        REG_AMP_SHIFT:      cfg.amp_shift      <= cfg_data[LEVEL_W-1:0];
        REG_STEP_COUNT:     cfg.step_count     <= cfg_data[SC_W-1:0];
        default: begin
          cfg.step_count <= cfg.step_count;
        end
      endcase
    end
  end

  // the front only refuses a beat when the queue is full
  assign busy = full;

  // front: classify each beat (table write, zero period, pre-apply, periodic lookup)
  psw_front u_front (
    .start       (start),
    .full        (full),
    .opcode      (opcode),
    .entry_index (entry_index),
    .entry_time  (entry_time),
    .entry_level (entry_level),
    .sample_time (sample_time),
    .cfg         (cfg),
    .push        (push),
    .item        (push_item)
  );

  // short queue between front and back, keeps beat order so writes and lookups stay in order
  psw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  // back: table memory, serial modulo by period, table walk and level add
  psw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .item      (pop_item),
    .pop       (pop),
    .level_out (level_out),
    .done      (done)
  );

endmodule
